>>> rtl/scp_pkg.sv
// Shared types and constants for the sprite camera projection block.
// Used by the top level and the testbench; no dependencies.
`timescale 1ns / 1ps

package scp_pkg;

	typedef enum logic [2:0] {
		RJ_SHOWN      = 3'd0,
		RJ_INACTIVE   = 3'd1,
		RJ_NEAR       = 3'd2,
		RJ_OFFSCREEN  = 3'd3,
		RJ_DEGENERATE = 3'd4
	} reject_t;

	typedef enum logic {
		CFG_FOCAL_LENGTH  = 1'b0,
		CFG_SPRITE_HEIGHT = 1'b1
	} cfg_reg_t;

	localparam logic [31:0] FOCAL_RESET  = 32'd36469271;
	localparam logic [31:0] HEIGHT_RESET = 32'd419430;

	// 0.2 and 0.1 in Q16.16, rounded to nearest
	localparam logic signed [31:0] NEAR_LIMIT  = 32'sd13107;
	localparam logic signed [31:0] DEPTH_FLOOR = 32'sd6554;

	localparam logic [31:0] SAT_MAX = 32'h7FFF_FFFF;
	localparam logic [31:0] SAT_MIN = 32'h8000_0000;

	// Fixed widths of the camera transform
	localparam int unsigned MAIN_NUM_W = 63;
	localparam int unsigned MAIN_DEN_W = 32;
	localparam int unsigned MAIN_Q_W   = 33;

endpackage

>>> rtl/scp_div_pipe.sv
// Pipelined unsigned restoring divider, one quotient bit per stage.
// Flags quotients that do not fit in Q_W bits. Standalone module.
`timescale 1ns / 1ps

module scp_div_pipe #(
	parameter int unsigned NUM_W  = 63,
	parameter int unsigned DEN_W  = 32,
	parameter int unsigned Q_W    = 33,
	parameter int unsigned SIDE_W = 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  logic [NUM_W-1:0]  num,
	input  logic [DEN_W-1:0]  den,
	input  logic [SIDE_W-1:0] side,
	output logic              out_valid,
	output logic [Q_W-1:0]    quo,
	output logic              ovf,
	output logic [SIDE_W-1:0] side_out
);

	localparam int unsigned HI_W = NUM_W - Q_W;
	localparam int unsigned CW   = (HI_W > DEN_W) ? HI_W : DEN_W;

	logic [Q_W:0]      v_s;
	logic [DEN_W-1:0]  rem_s  [Q_W+1];
	logic [DEN_W-1:0]  den_s  [Q_W+1];
	logic [Q_W-1:0]    low_s  [Q_W+1];
	logic [Q_W-1:0]    quo_s  [Q_W+1];
	logic              ovf_s  [Q_W+1];
	logic [SIDE_W-1:0] side_s [Q_W+1];

	logic [CW-1:0] hi_ext;
	logic [CW-1:0] den_ext;

	assign hi_ext  = CW'(num[NUM_W-1:Q_W]);
	assign den_ext = CW'(den);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else if (en) begin
			v_s <= {v_s[Q_W-1:0], in_valid};
		end
	end

	// Entry: upper numerator bits become the first partial remainder
	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0]  <= DEN_W'(hi_ext);
			ovf_s[0]  <= (hi_ext >= den_ext);
			den_s[0]  <= den;
			low_s[0]  <= num[Q_W-1:0];
			quo_s[0]  <= '0;
			side_s[0] <= side;
		end
	end

	for (genvar k = 1; k <= Q_W; k++) begin : g_stage
		logic [DEN_W:0] trial;
		logic [DEN_W:0] diff;
		logic           ge;

		assign trial = {rem_s[k-1], low_s[k-1][Q_W-1]};
		assign diff  = trial - {1'b0, den_s[k-1]};
		assign ge    = (trial >= {1'b0, den_s[k-1]});

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k]  <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
				quo_s[k]  <= {quo_s[k-1][Q_W-2:0], ge};
				low_s[k]  <= {low_s[k-1][Q_W-2:0], 1'b0};
				den_s[k]  <= den_s[k-1];
				ovf_s[k]  <= ovf_s[k-1];
				side_s[k] <= side_s[k-1];
			end
		end
	end

	assign out_valid = v_s[Q_W];
	assign quo       = quo_s[Q_W];
	assign ovf       = ovf_s[Q_W];
	assign side_out  = side_s[Q_W];

endmodule

>>> rtl/sprite_camera_projection.sv
// Sprite camera projection: camera transform, reject checks, column and size.
// Depends on scp_pkg and scp_div_pipe.
`timescale 1ns / 1ps

// Usage
//   Input channel in_valid/in_ready carries one sprite per beat: world
//   position, viewer position, direction and camera plane vectors.
//   Output channel out_valid/out_ready returns exactly one result per beat:
//   shown flag, reject code, screen column, clamped size and camera depth.
//   Configuration: cfg_we with cfg_index selects focal_length (0) or
//   sprite_world_height (1); write only while the pipeline is empty.
// Pipeline: 3 input stages, the camera-transform dividers, 3 post stages,
//   the column/size dividers and 1 output register.
// Throughput: one sprite per cycle unless the output stalls; every divider
//   is unrolled into one register stage per quotient bit.
// Stall: the whole pipeline holds while the output register is full and
//   out_ready is low; in_ready drops in the same cycle, nothing is lost.
// Reset: valid bits clear, the configuration registers return to their reset values.

module sprite_camera_projection #(
	parameter int unsigned SCREEN_WIDTH  = 1024,
	parameter int unsigned SCREEN_HEIGHT = 768
) (
	input  logic               clk,
	input  logic               arst_n,

	input  logic               cfg_we,
	input  logic               cfg_index,
	input  logic [31:0]        cfg_data,

	input  logic               in_valid,
	output logic               in_ready,
	input  logic               sprite_active,
	input  logic signed [31:0] sprite_x,
	input  logic signed [31:0] sprite_y,
	input  logic signed [31:0] viewer_x,
	input  logic signed [31:0] viewer_y,
	input  logic signed [15:0] dir_vec_x,
	input  logic signed [15:0] dir_vec_y,
	input  logic signed [15:0] plane_vec_x,
	input  logic signed [15:0] plane_vec_y,

	output logic               out_valid,
	input  logic               out_ready,
	output logic               shown,
	output logic [2:0]         reject_code,
	output logic [9:0]         screen_column,
	output logic [10:0]        size_px,
	output logic signed [31:0] camera_depth
);

	localparam int unsigned HALF   = SCREEN_WIDTH / 2;
	localparam int unsigned HALF_W = $clog2(HALF + 1);
	localparam int unsigned LIMIT  = 2 * SCREEN_HEIGHT;
	localparam int unsigned QC_W   = $clog2(SCREEN_WIDTH + 1);
	localparam int unsigned SZ_W   = $clog2(LIMIT + 1);
	localparam int unsigned DQ_A   = (QC_W > SZ_W) ? QC_W : SZ_W;
	localparam int unsigned DQ_W   = (DQ_A > 11) ? DQ_A : 11;
	localparam int unsigned CN_W   = 33 + HALF_W;
	localparam int unsigned CSIDE_W = 35;

	localparam int unsigned MN_W = scp_pkg::MAIN_NUM_W;
	localparam int unsigned MD_W = scp_pkg::MAIN_DEN_W;
	localparam int unsigned MQ_W = scp_pkg::MAIN_Q_W;

	logic en;

	// Configuration
	logic [31:0] focal_q;
	logic [31:0] height_q;
	logic [63:0] prod_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			focal_q  <= scp_pkg::FOCAL_RESET;
			height_q <= scp_pkg::HEIGHT_RESET;
		end else if (cfg_we) begin
			case (scp_pkg::cfg_reg_t'(cfg_index))
				scp_pkg::CFG_FOCAL_LENGTH:  focal_q  <= cfg_data;
				scp_pkg::CFG_SPRITE_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= 64'(height_q) * 64'(focal_q);
	end

	// Stage 1: offsets
	logic               v_s1;
	logic               act_s1;
	logic signed [32:0] dx_s1, dy_s1;
	logic signed [15:0] dvx_s1, dvy_s1, pvx_s1, pvy_s1;

	// Stage 2: products
	logic               v_s2;
	logic               act_s2;
	logic signed [48:0] pa_s2, pb_s2, pc_s2, pd_s2;
	logic signed [31:0] da_s2, db_s2;

	// Stage 3: numerators and determinant as magnitudes
	logic               v_s3;
	logic               act_s3, dz_s3, lneg_s3, dneg_s3;
	logic [MN_W-1:0]    lnum_s3, dnum_s3;
	logic [MD_W-1:0]    det_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			act_s1 <= sprite_active;
			dx_s1  <= {sprite_x[31], sprite_x} - {viewer_x[31], viewer_x};
			dy_s1  <= {sprite_y[31], sprite_y} - {viewer_y[31], viewer_y};
			dvx_s1 <= dir_vec_x;
			dvy_s1 <= dir_vec_y;
			pvx_s1 <= plane_vec_x;
			pvy_s1 <= plane_vec_y;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			act_s2 <= act_s1;
			pa_s2  <= dvy_s1 * dx_s1;
			pb_s2  <= dvx_s1 * dy_s1;
			pc_s2  <= pvx_s1 * dy_s1;
			pd_s2  <= pvy_s1 * dx_s1;
			da_s2  <= pvx_s1 * dvy_s1;
			db_s2  <= dvx_s1 * pvy_s1;
		end
	end

	logic signed [49:0] nl_c, nd_c;
	logic signed [32:0] det_c;
	logic [49:0]        nl_abs, nd_abs;
	logic [32:0]        det_abs;

	always_comb begin
		nl_c    = {pa_s2[48], pa_s2} - {pb_s2[48], pb_s2};
		nd_c    = {pc_s2[48], pc_s2} - {pd_s2[48], pd_s2};
		det_c   = {da_s2[31], da_s2} - {db_s2[31], db_s2};
		nl_abs  = nl_c[49] ? (50'd0 - nl_c) : nl_c;
		nd_abs  = nd_c[49] ? (50'd0 - nd_c) : nd_c;
		det_abs = det_c[32] ? (33'd0 - det_c) : det_c;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			act_s3  <= act_s2;
			dz_s3   <= (det_c == '0);
			lneg_s3 <= nl_c[49] ^ det_c[32];
			dneg_s3 <= nd_c[49] ^ det_c[32];
			lnum_s3 <= {nl_abs[48:0], 14'd0};
			dnum_s3 <= {nd_abs[48:0], 14'd0};
			det_s3  <= det_abs[31:0];
		end
	end

	// Camera transform dividers
	logic            lv_m, dv_m;
	logic [MQ_W-1:0] lq_m, dq_m;
	logic            lo_m, do_m;
	logic            lneg_m;
	logic [2:0]      dside_m;

	scp_div_pipe #(
		.NUM_W(MN_W), .DEN_W(MD_W), .Q_W(MQ_W), .SIDE_W(1)
	) u_div_lat (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(v_s3),
		.num(lnum_s3), .den(det_s3), .side(lneg_s3),
		.out_valid(lv_m), .quo(lq_m), .ovf(lo_m), .side_out(lneg_m)
	);

	scp_div_pipe #(
		.NUM_W(MN_W), .DEN_W(MD_W), .Q_W(MQ_W), .SIDE_W(3)
	) u_div_depth (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(v_s3),
		.num(dnum_s3), .den(det_s3), .side({act_s3, dz_s3, dneg_s3}),
		.out_valid(dv_m), .quo(dq_m), .ovf(do_m), .side_out(dside_m)
	);

	function automatic logic [31:0] sat_q(input logic [32:0] q, input logic o,
		input logic neg);
		logic [32:0] nq;
		nq = 33'd0 - q;
		if (!neg) begin
			sat_q = (o || q[32:31] != 2'b00) ? scp_pkg::SAT_MAX : q[31:0];
		end else begin
			sat_q = (o || q > 33'h1_0000_0000 >> 1) ? scp_pkg::SAT_MIN : nq[31:0];
		end
	endfunction

	// Post stages
	logic               v_p1, v_p2, v_p3;
	logic               act_p1, dz_p1, act_p2, dz_p2, act_p3, dz_p3;
	logic signed [31:0] lat_p1, dep_p1, dep_p2, dep_p3;
	logic signed [32:0] sum_p2;
	logic               near_p2, near_p3, sneg_p3;
	logic [CN_W-1:0]    cnum_p3;
	logic [31:0]        corr_p3;
	logic [32:0]        sum_abs;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_p1 <= 1'b0;
			v_p2 <= 1'b0;
			v_p3 <= 1'b0;
		end else if (en) begin
			v_p1 <= lv_m & dv_m;
			v_p2 <= v_p1;
			v_p3 <= v_p2;
		end
	end

	assign sum_abs = sum_p2[32] ? (33'd0 - sum_p2) : sum_p2;

	always_ff @(posedge clk) begin
		if (en) begin
			act_p1  <= dside_m[2];
			dz_p1   <= dside_m[1];
			lat_p1  <= sat_q(lq_m, lo_m, lneg_m);
			dep_p1  <= sat_q(dq_m, do_m, dside_m[0]);

			act_p2  <= act_p1;
			dz_p2   <= dz_p1;
			dep_p2  <= dep_p1;
			sum_p2  <= {lat_p1[31], lat_p1} + {dep_p1[31], dep_p1};
			near_p2 <= (dep_p1 <= scp_pkg::NEAR_LIMIT);

			act_p3  <= act_p2;
			dz_p3   <= dz_p2;
			dep_p3  <= dep_p2;
			near_p3 <= near_p2;
			sneg_p3 <= sum_p2[32];
			cnum_p3 <= CN_W'(sum_abs) * CN_W'(HALF);
			corr_p3 <= (dep_p2 < scp_pkg::DEPTH_FLOOR) ? scp_pkg::DEPTH_FLOOR : dep_p2;
		end
	end

	// Column and size dividers
	logic                cv_d, sv_d;
	logic [DQ_W-1:0]     cq_d, sq_d;
	logic                co_d, so_d;
	logic [CSIDE_W-1:0]  cside_d;
	logic                sneg_d;

	scp_div_pipe #(
		.NUM_W(CN_W), .DEN_W(32), .Q_W(DQ_W), .SIDE_W(CSIDE_W)
	) u_div_col (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(v_p3),
		.num(cnum_p3), .den(corr_p3),
		.side({act_p3, dz_p3, near_p3, dep_p3}),
		.out_valid(cv_d), .quo(cq_d), .ovf(co_d), .side_out(cside_d)
	);

	scp_div_pipe #(
		.NUM_W(48), .DEN_W(32), .Q_W(DQ_W), .SIDE_W(1)
	) u_div_size (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(v_p3),
		.num(prod_q[63:16]), .den(corr_p3), .side(sneg_p3),
		.out_valid(sv_d), .quo(sq_d), .ovf(so_d), .side_out(sneg_d)
	);

	// Result selection
	logic               off_c;
	logic [DQ_W-1:0]    size_c;
	scp_pkg::reject_t   code_c;
	logic signed [31:0] dep_d;

	assign dep_d = cside_d[31:0];

	always_comb begin
		off_c = co_d || (sneg_d ? (cq_d != '0) : (cq_d >= DQ_W'(SCREEN_WIDTH)));
		if (so_d || sq_d > DQ_W'(LIMIT)) begin
			size_c = DQ_W'(LIMIT);
		end else if (sq_d == '0) begin
			size_c = DQ_W'(1);
		end else begin
			size_c = sq_d;
		end
		if (!cside_d[34]) begin
			code_c = scp_pkg::RJ_INACTIVE;
		end else if (cside_d[33]) begin
			code_c = scp_pkg::RJ_DEGENERATE;
		end else if (cside_d[32]) begin
			code_c = scp_pkg::RJ_NEAR;
		end else if (off_c) begin
			code_c = scp_pkg::RJ_OFFSCREEN;
		end else begin
			code_c = scp_pkg::RJ_SHOWN;
		end
	end

	// Output register
	logic out_valid_q;

	assign en       = !out_valid_q || out_ready;
	assign in_ready = en;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= cv_d & sv_d;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			shown         <= (code_c == scp_pkg::RJ_SHOWN);
			reject_code   <= code_c;
			screen_column <= (code_c == scp_pkg::RJ_SHOWN) ? cq_d[9:0] : 10'd0;
			size_px       <= (code_c == scp_pkg::RJ_SHOWN) ? size_c[10:0] : 11'd0;
			camera_depth  <= (code_c == scp_pkg::RJ_INACTIVE ||
				code_c == scp_pkg::RJ_DEGENERATE) ? 32'sd0 : dep_d;
		end
	end

endmodule

>>> bench/tb_sprite_camera_projection.sv
// Testbench for sprite_camera_projection: directed and random sprites, several register
// settings, random gaps on both channels, scoreboard with its own projection predictor.
// Depends on scp_pkg and the RTL of the block only.
`timescale 1ns / 1ps

module tb_sprite_camera_projection;

	localparam int SCR_W = 1024;
	localparam int SCR_H = 768;
	localparam int DRAIN_CYCLES = 70;

	typedef struct {
		logic               active;
		logic signed [31:0] sx, sy, vx, vy;
		logic signed [15:0] dirx, diry, plx, ply;
	} sprite_t;

	typedef struct {
		logic               shown;
		scp_pkg::reject_t   code;
		logic [9:0]         column;
		logic [10:0]        size;
		logic signed [31:0] depth;
	} proj_t;

	class projection_scoreboard;
		logic [31:0] focal;
		logic [31:0] height;
		proj_t       expected_q[$];
		int          errors;
		int          checked;
		int          code_seen[5];

		function void reset_regs();
			focal  = scp_pkg::FOCAL_RESET;
			height = scp_pkg::HEIGHT_RESET;
		endfunction

		function void set_reg(scp_pkg::cfg_reg_t idx, logic [31:0] v);
			if (idx == scp_pkg::CFG_FOCAL_LENGTH)
				focal = v;
			else
				height = v;
		endfunction

		function longint sat32(longint v);
			if (v > longint'(32'sh7FFF_FFFF))
				return longint'(32'sh7FFF_FFFF);
			if (v < -longint'(64'h8000_0000))
				return -longint'(64'h8000_0000);
			return v;
		endfunction

		function proj_t project(sprite_t s);
			longint      dx, dy, det, lat, dep, col;
			logic [63:0] corr, size;
			proj_t       r;
			r.shown  = 1'b0;
			r.column = '0;
			r.size   = '0;
			r.depth  = '0;
			if (!s.active) begin
				r.code = scp_pkg::RJ_INACTIVE;
				return r;
			end
			det = longint'(s.plx) * longint'(s.diry) - longint'(s.dirx) * longint'(s.ply);
			if (det == 0) begin
				r.code = scp_pkg::RJ_DEGENERATE;
				return r;
			end
			dx  = longint'(s.sx) - longint'(s.vx);
			dy  = longint'(s.sy) - longint'(s.vy);
			lat = sat32(((longint'(s.diry) * dx - longint'(s.dirx) * dy) * 16384) / det);
			dep = sat32(((longint'(s.plx) * dy - longint'(s.ply) * dx) * 16384) / det);
			r.depth = dep[31:0];
			if (dep <= longint'(scp_pkg::NEAR_LIMIT)) begin
				r.code = scp_pkg::RJ_NEAR;
				return r;
			end
			col = (longint'(SCR_W / 2) * (dep + lat)) / dep;
			if (col < 0 || col >= SCR_W) begin
				r.code = scp_pkg::RJ_OFFSCREEN;
				return r;
			end
			corr = (dep < longint'(scp_pkg::DEPTH_FLOOR)) ? 64'(scp_pkg::DEPTH_FLOOR)
				: 64'(dep);
			size = (64'(height) * 64'(focal)) / (corr << 16);
			if (size > 64'(2 * SCR_H))
				size = 64'(2 * SCR_H);
			if (size < 64'd1)
				size = 64'd1;
			r.shown  = 1'b1;
			r.code   = scp_pkg::RJ_SHOWN;
			r.column = col[9:0];
			r.size   = size[10:0];
			return r;
		endfunction

		function void note_sprite(sprite_t s);
			expected_q.push_back(project(s));
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		task report(string msg);
			$display("[%0t] mismatch: %s", $realtime, msg);
			errors++;
		endtask

		task check_result(proj_t got);
			proj_t e;
			if (expected_q.size() == 0) begin
				report("result beat with nothing expected");
				return;
			end
			e = expected_q.pop_front();
			checked++;
			code_seen[e.code]++;
			if (got.shown !== e.shown)
				report($sformatf("shown %0b, expected %0b", got.shown, e.shown));
			if (got.code !== e.code)
				report($sformatf("reject_code %0d, expected %0d", got.code, e.code));
			if (got.column !== e.column)
				report($sformatf("screen_column %0d, expected %0d", got.column, e.column));
			if (got.size !== e.size)
				report($sformatf("size_px %0d, expected %0d", got.size, e.size));
			if (got.depth !== e.depth)
				report($sformatf("camera_depth %h, expected %h", got.depth, e.depth));
		endtask
	endclass

	logic               clk;
	logic               arst_n;
	logic               cfg_we;
	logic               cfg_index;
	logic [31:0]        cfg_data;
	logic               in_valid;
	logic               in_ready;
	logic               sprite_active;
	logic signed [31:0] sprite_x, sprite_y, viewer_x, viewer_y;
	logic signed [15:0] dir_vec_x, dir_vec_y, plane_vec_x, plane_vec_y;
	logic               out_valid;
	logic               out_ready;
	logic               shown;
	logic [2:0]         reject_code;
	logic [9:0]         screen_column;
	logic [10:0]        size_px;
	logic signed [31:0] camera_depth;

	projection_scoreboard sb;
	bit steady;

	sprite_camera_projection dut (.*);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	function automatic sprite_t mk(int a, int sx, int sy, int vx, int vy,
			int dx, int dy, int px, int py);
		sprite_t s;
		s.active = a[0];
		s.sx = sx; s.sy = sy; s.vx = vx; s.vy = vy;
		s.dirx = 16'(dx); s.diry = 16'(dy); s.plx = 16'(px); s.ply = 16'(py);
		return s;
	endfunction

	// Mostly a proper camera (plane perpendicular to dir) with the sprite placed
	// at a chosen depth and lateral offset; the rest is raw noise.
	function automatic sprite_t random_sprite();
		sprite_t s;
		longint  dep, lat, ox, oy;
		int      dx, dy, px, py, k;
		if ($urandom_range(99) < 25) begin
			s = mk($urandom, $urandom, $urandom, $urandom, $urandom,
				$urandom, $urandom, $urandom, $urandom);
			if ($urandom_range(3) != 0)
				s.active = 1'b1;
			return s;
		end
		dx  = $urandom_range(32768) - 16384;
		dy  = $urandom_range(32768) - 16384;
		k   = $urandom_range(16384, 6000);
		px  = (dy * k) >>> 14;
		py  = -((dx * k) >>> 14);
		dep = longint'($urandom_range(40 << 16)) - (2 << 16);
		lat = longint'($urandom_range(2 * (24 << 16))) - (24 << 16);
		ox  = (dx * dep + px * lat) >>> 14;
		oy  = (dy * dep + py * lat) >>> 14;
		s = mk(int'($urandom_range(15) != 0), 0, 0, $urandom, $urandom, dx, dy, px, py);
		if ($urandom_range(1))
			s.vx = $signed(32'($urandom_range(1 << 22))) - (1 << 21);
		s.sx = s.vx + 32'(ox);
		s.sy = s.vy + 32'(oy);
		return s;
	endfunction

	task automatic send_sprite(sprite_t s);
		while (!steady && $urandom_range(99) < 37) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid      <= 1'b1;
		sprite_active <= s.active;
		sprite_x      <= s.sx;
		sprite_y      <= s.sy;
		viewer_x      <= s.vx;
		viewer_y      <= s.vy;
		dir_vec_x     <= s.dirx;
		dir_vec_y     <= s.diry;
		plane_vec_x   <= s.plx;
		plane_vec_y   <= s.ply;
		do @(posedge clk); while (!in_ready);
		sb.note_sprite(s);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(scp_pkg::cfg_reg_t idx, logic [31:0] v);
		wait_drained();
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_reg(idx, v);
	endtask

	// Result side: random stalls, check every beat
	initial begin
		out_ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (out_valid && out_ready)
				sb.check_result('{shown, scp_pkg::reject_t'(reject_code), screen_column,
					size_px, camera_depth});
			out_ready <= steady || ($urandom_range(99) >= 37);
		end
	end

	initial begin
		#2_000_000;
		$display("Regression FAIL");
		$finish;
	end

	initial begin
		int          n;
		logic [31:0] lo;
		sb = new();
		sb.reset_regs();
		steady = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0; cfg_index = scp_pkg::CFG_FOCAL_LENGTH; cfg_data = '0;
		in_valid = 1'b0; sprite_active = 1'b0;
		sprite_x = '0; sprite_y = '0; viewer_x = '0; viewer_y = '0;
		dir_vec_x = '0; dir_vec_y = '0; plane_vec_x = '0; plane_vec_y = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: mostly a forward camera, dir (0,1), plane (0.66,0); the rest vary the vectors
		send_sprite(mk(0, 0, 5 << 16, 0, 0, 0, 16384, 10813, 0));
		send_sprite(mk(1, 0, 5 << 16, 0, 0, 0, 0, 0, 0));
		send_sprite(mk(1, 0, 5 << 16, 0, 0, 16384, 16384, 16384, 16384));
		send_sprite(mk(1, 0, 5 << 16, 0, 0, 0, 16384, 10813, 0));
		send_sprite(mk(1, 0, 0, 0, 0, 0, 16384, 10813, 0));
		send_sprite(mk(1, 0, -(3 << 16), 0, 0, 0, 16384, 10813, 0));
		send_sprite(mk(1, 0, 13107, 0, 0, 0, 16384, 10813, 0));
		send_sprite(mk(1, 0, 13108, 0, 0, 0, 16384, 10813, 0));
		send_sprite(mk(1, 10 << 16, 5 << 16, 0, 0, 0, 16384, 10813, 0));
		send_sprite(mk(1, -(10 << 16), 5 << 16, 0, 0, 0, 16384, 10813, 0));
		send_sprite(mk(1, 0, 1000 << 16, 0, 0, 0, 16384, 10813, 0));
		send_sprite(mk(1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
			0, 16384, 10813, 0));
		send_sprite(mk(1, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
			0, 16384, 10813, 0));
		send_sprite(mk(1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
			-32768, 32767, 32767, -32768));
		send_sprite(mk(1, 3 << 16, 4 << 16, 0, 0, 1, 0, 0, 1));
		send_sprite(mk(1, 0, 2 << 16, 0, 0, 0, 32767, 32767, 0));
		send_sprite(mk(1, 0, 5 << 16, 0, 0, 0, -32768, -32768, 0));
		send_sprite(mk(1, -1, -1, -1, -1, -1, -1, -1, 1));

		// Five register settings: reset values, zero, all ones, random, random up to 2^26 and 2^21
		for (int phase = 0; phase < 5; phase++) begin
			case (phase)
				1: begin
					write_reg(scp_pkg::CFG_FOCAL_LENGTH, '0);
					write_reg(scp_pkg::CFG_SPRITE_HEIGHT, '0);
				end
				2: begin
					write_reg(scp_pkg::CFG_FOCAL_LENGTH, 32'hFFFF_FFFF);
					write_reg(scp_pkg::CFG_SPRITE_HEIGHT, 32'hFFFF_FFFF);
				end
				3: begin
					write_reg(scp_pkg::CFG_FOCAL_LENGTH, $urandom);
					write_reg(scp_pkg::CFG_SPRITE_HEIGHT, $urandom);
				end
				4: begin
					lo = $urandom_range(1 << 26);
					write_reg(scp_pkg::CFG_FOCAL_LENGTH, lo);
					write_reg(scp_pkg::CFG_SPRITE_HEIGHT, $urandom_range(1 << 21));
				end
				default: ;
			endcase
			for (n = 0; n < 170; n++) begin
				steady = (phase == 2 && n >= 30 && n < 130);
				if (phase == 3 && n == 85)
					wait_drained();
				send_sprite(random_sprite());
			end
		end
		steady = 1'b0;
		in_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Checked %0d results: %0d shown, %0d inactive, %0d near, %0d off screen,",
			sb.checked, sb.code_seen[scp_pkg::RJ_SHOWN], sb.code_seen[scp_pkg::RJ_INACTIVE],
			sb.code_seen[scp_pkg::RJ_NEAR], sb.code_seen[scp_pkg::RJ_OFFSCREEN]);
		$display("%0d degenerate, over five register settings; %0d mismatches",
			sb.code_seen[scp_pkg::RJ_DEGENERATE], sb.errors);
		if (sb.errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end
endmodule

>>> files.f
rtl/scp_pkg.sv
rtl/scp_div_pipe.sv
rtl/sprite_camera_projection.sv
bench/tb_sprite_camera_projection.sv
